@@ rtl/rmv_pkg.sv @@
// Shared widths, register indexes and transaction types for the running
// mean / variance / standard deviation unit.
// No dependencies; imported by every module under rtl/.
package rmv_pkg;

    localparam int CAPACITY = 128;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 8;
    localparam int SUM_W    = 24;
    localparam int SUMSQ_W  = 38;
    localparam int XING_W   = 7;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 39;
    localparam int SD_W     = 24;
    localparam int CFG_W    = 16;

    // width of the shared subtract/compare unit (root step is the widest)
    localparam int ALU_W    = 27;

    localparam logic signed [SAMPLE_W-1:0] END_MARKER_RST = 16'sd9999;
    localparam logic [COUNT_W-1:0]         SET_LIMIT_RST  = 8'd100;

    typedef enum logic {
        CFG_END_MARKER = 1'b0,
        CFG_SET_LIMIT  = 1'b1
    } t_cfg_idx;

    // snapshot of a closed set, handed to the finishing sequencer
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic signed [SUM_W-1:0]   sum;
        logic [SUMSQ_W-1:0]        sumsq;
        logic [XING_W-1:0]         xings;
        logic                      overflow;
    } t_stats;

    typedef struct packed {
        logic [COUNT_W-1:0]        sample_count;
        logic signed [MEAN_W-1:0]  mean_q8;
        logic [VAR_W-1:0]          variance_q8;
        logic [SD_W-1:0]           std_dev_q8;
        logic [XING_W-1:0]         zero_crossings;
        logic                      overflow;
        logic                      empty_set;
    } t_result;

endpackage

@@ rtl/rmv_alu.sv @@
// Shared subtract/compare unit used by every divide and square-root step.
// Depends on rmv_pkg (ALU_W).
module rmv_alu (
    input  logic [rmv_pkg::ALU_W-1:0] i_a,
    input  logic [rmv_pkg::ALU_W-1:0] i_b,
    output logic [rmv_pkg::ALU_W-1:0] o_diff,
    output logic                      o_ge
);
    import rmv_pkg::*;

    logic [ALU_W:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[ALU_W-1:0];
    assign o_ge   = ~w_full[ALU_W];

endmodule

@@ rtl/rmv_finish.sv @@
// Finishing sequencer: products, then mean divide, variance divide and square
// root, the last three stepping through one shared subtract/compare unit.
// Depends on rmv_pkg and rmv_alu.
module rmv_finish (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rmv_pkg::t_stats  i_stats,
    input  logic             i_ack,
    output logic             o_done,
    output rmv_pkg::t_result o_result
);
    import rmv_pkg::*;

    localparam int AM_W     = SUM_W - 1;           // |sum| <= CAPACITY * 2^15
    localparam int PROD_W   = 46;
    localparam int D_W      = 45;
    localparam int N2_W     = 15;
    localparam int DVD_W    = D_W + 16;            // 61
    localparam int REM_W    = 16;
    localparam int QUO_W    = 48;
    localparam int SREM_W   = 25;
    localparam int CNT_W    = 6;
    localparam int DIVM_STEPS = AM_W + 8;          // 31
    localparam int DIVV_STEPS = DVD_W;             // 61
    localparam int SQRT_STEPS = SD_W;              // 24

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_DIFF, F_DIVM, F_DIVV, F_SQRT, F_DONE
    } t_fstate;

    t_fstate                   r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [COUNT_W-1:0]        r_n;
    logic [AM_W-1:0]           r_am;
    logic                      r_neg;
    logic [SUMSQ_W-1:0]        r_sumsq;
    logic [XING_W-1:0]         r_xings;
    logic                      r_ovf;
    logic [PROD_W-1:0]         r_nsq;
    logic [PROD_W-1:0]         r_am2;
    logic [N2_W-1:0]           r_n2;
    logic [D_W-1:0]            r_d;
    logic [DVD_W-1:0]          r_dvd;
    logic [N2_W-1:0]           r_dvsr;
    logic [REM_W-1:0]          r_rem;
    logic [QUO_W-1:0]          r_quo;
    logic [SREM_W-1:0]         r_srem;
    logic [SD_W-1:0]           r_root;
    logic signed [MEAN_W-1:0]  r_mean;
    logic [VAR_W-1:0]          r_var;
    logic [SD_W-1:0]           r_sd;

    logic [REM_W:0]            w_div_t;
    logic [ALU_W-1:0]          w_sq_t;
    logic [ALU_W-1:0]          w_alu_a;
    logic [ALU_W-1:0]          w_alu_b;
    logic [ALU_W-1:0]          w_diff;
    logic                      w_ge;
    logic [QUO_W-1:0]          n_quo;
    logic [SD_W-1:0]           n_root;
    logic [SUM_W-1:0]          w_abs;

    assign w_div_t = {r_rem, r_dvd[DVD_W-1]};
    assign w_sq_t  = {r_srem, r_quo[QUO_W-1 -: 2]};
    assign n_quo   = {r_quo[QUO_W-2:0], w_ge};
    assign n_root  = {r_root[SD_W-2:0], w_ge};
    assign w_abs   = i_stats.sum[SUM_W-1] ? (-i_stats.sum) : i_stats.sum;

    always_comb begin
        case (r_state)
            F_DIVM, F_DIVV: begin
                w_alu_a = ALU_W'(w_div_t);
                w_alu_b = ALU_W'(r_dvsr);
            end
            F_SQRT: begin
                w_alu_a = w_sq_t;
                w_alu_b = ALU_W'({r_root, 2'b01});
            end
            default: begin
                w_alu_a = '0;
                w_alu_b = '0;
            end
        endcase
    end

    rmv_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_stats.count;
                        r_am    <= w_abs[AM_W-1:0];
                        r_neg   <= i_stats.sum[SUM_W-1];
                        r_sumsq <= i_stats.sumsq;
                        r_xings <= i_stats.xings;
                        r_ovf   <= i_stats.overflow;
                        r_mean  <= '0;
                        r_var   <= '0;
                        r_sd    <= '0;
                        // empty set skips the arithmetic, stats stay zero
                        r_state <= (i_stats.count == '0) ? F_DONE : F_MUL;
                    end
                end
                F_MUL: begin
                    r_nsq   <= PROD_W'(r_n) * PROD_W'(r_sumsq);
                    r_am2   <= PROD_W'(r_am) * PROD_W'(r_am);
                    r_n2    <= N2_W'(r_n) * N2_W'(r_n);
                    r_state <= F_DIFF;
                end
                F_DIFF: begin
                    r_d     <= D_W'(r_nsq - r_am2);
                    r_dvd   <= {r_am, 8'b0, (DVD_W-AM_W-8)'(0)};
                    r_dvsr  <= N2_W'(r_n);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= CNT_W'(DIVM_STEPS - 1);
                    r_state <= F_DIVM;
                end
                F_DIVM, F_DIVV: begin
                    if (r_cnt != '0) begin
                        r_rem <= w_ge ? w_diff[REM_W-1:0] : w_div_t[REM_W-1:0];
                        r_quo <= n_quo;
                        r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_state == F_DIVM) begin
                        r_mean  <= r_neg ? -$signed(n_quo[MEAN_W-1:0])
                                         : $signed(n_quo[MEAN_W-1:0]);
                        r_dvd   <= {r_d, 16'b0};
                        r_dvsr  <= r_n2;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= CNT_W'(DIVV_STEPS - 1);
                        r_state <= F_DIVV;
                    end else begin
                        // quotient holds variance with 16 fraction bits
                        r_quo   <= n_quo;
                        r_var   <= n_quo[VAR_W+7:8];
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNT_W'(SQRT_STEPS - 1);
                        r_state <= F_SQRT;
                    end
                end
                F_SQRT: begin
                    r_srem <= w_ge ? w_diff[SREM_W-1:0] : w_sq_t[SREM_W-1:0];
                    r_root <= n_root;
                    r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_sd    <= n_root;
                        r_state <= F_DONE;
                    end
                end
                F_DONE: begin
                    if (i_ack) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == F_DONE);

    always_comb begin
        o_result.sample_count   = r_n;
        o_result.mean_q8        = r_mean;
        o_result.variance_q8    = r_var;
        o_result.std_dev_q8     = r_sd;
        o_result.zero_crossings = r_xings;
        o_result.overflow       = r_ovf;
        o_result.empty_set      = (r_n == '0);
    end

endmodule

@@ rtl/running_mean_variance_stdev_unit.sv @@
// Running statistics over sets of signed 16-bit samples. Each accepted sample
// is captured, then accumulated into count, sum, sum of squares and crossing
// count, with input stall high while it accumulates. When a set closes, on the
// end marker or on reaching the set limit, input stays stalled while the
// finishing sequencer runs its one subtract/compare unit through a 31-step
// mean divide, a 61-step variance divide and a 24-step square root; an empty
// set skips them. The result register frees the finisher as soon as the
// previous result is taken, and sample input resumes at once.
module running_mean_variance_stdev_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [rmv_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [rmv_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rmv_pkg::COUNT_W-1:0]       o_sample_count,
    output logic signed [rmv_pkg::MEAN_W-1:0] o_mean_q8,
    output logic [rmv_pkg::VAR_W-1:0]         o_variance_q8,
    output logic [rmv_pkg::SD_W-1:0]          o_std_dev_q8,
    output logic [rmv_pkg::XING_W-1:0]        o_zero_crossings,
    output logic                              o_overflow,
    output logic                              o_empty_set
);
    import rmv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ACC, S_CALC} t_state;

    t_state                       r_state;
    logic signed [SAMPLE_W-1:0]   r_end_marker;
    logic [COUNT_W-1:0]           r_set_limit;
    logic signed [SAMPLE_W-1:0]   r_samp;
    logic [COUNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]      r_sum;
    logic [SUMSQ_W-1:0]           r_sumsq;
    logic signed [SAMPLE_W-1:0]   r_prev;
    logic [XING_W-1:0]            r_xings;
    logic                         r_out_valid;
    t_result                      r_out;

    logic [COUNT_W-1:0]           w_lim;
    logic                         w_mark;
    logic signed [2*SAMPLE_W-1:0] w_sq;
    logic                         w_cross;
    logic                         w_limit_hit;
    logic                         w_start;
    logic                         w_load;
    logic                         w_fin_done;
    logic [COUNT_W-1:0]           n_count;
    logic signed [SUM_W-1:0]      n_sum;
    logic [SUMSQ_W-1:0]           n_sumsq;
    logic [XING_W-1:0]            n_xings;
    t_stats                       w_stats;
    t_result                      w_fin_result;

    always_comb begin
        if (r_set_limit == '0) begin
            w_lim = COUNT_W'(1);
        end else if (r_set_limit > COUNT_W'(CAPACITY)) begin
            w_lim = COUNT_W'(CAPACITY);
        end else begin
            w_lim = r_set_limit;
        end
    end

    assign w_mark  = (r_samp == r_end_marker);
    assign w_sq    = r_samp * r_samp;
    assign w_cross = (r_count != '0) &&
                     (((r_samp < 0) && (r_prev > 0)) || ((r_samp > 0) && (r_prev < 0)));
    assign n_count = r_count + 1'b1;
    assign n_sum   = r_sum + SUM_W'(r_samp);
    assign n_sumsq = r_sumsq + SUMSQ_W'(unsigned'(w_sq));
    assign n_xings = r_xings + XING_W'(w_cross);
    assign w_limit_hit = (n_count >= w_lim);

    // marker closes the set as it stands; otherwise the updated sums close it
    always_comb begin
        if (w_mark) begin
            w_stats = '{count: r_count, sum: r_sum, sumsq: r_sumsq,
                        xings: r_xings, overflow: 1'b0};
        end else begin
            w_stats = '{count: n_count, sum: n_sum, sumsq: n_sumsq,
                        xings: n_xings, overflow: 1'b1};
        end
    end

    assign w_start = (r_state == S_ACC) && (w_mark || w_limit_hit);
    assign w_load  = (r_state == S_CALC) && w_fin_done && (!r_out_valid || !i_out_stall);

    rmv_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_stats  (w_stats),
        .i_ack    (w_load),
        .o_done   (w_fin_done),
        .o_result (w_fin_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_end_marker <= END_MARKER_RST;
            r_set_limit  <= SET_LIMIT_RST;
            r_count      <= '0;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_prev       <= '0;
            r_xings      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_END_MARKER: r_end_marker <= $signed(i_cfg_data[SAMPLE_W-1:0]);
                    CFG_SET_LIMIT:  r_set_limit  <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // a new result may land in the same cycle the old one is taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_samp  <= i_sample;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_start) begin
                        r_count <= '0;
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_prev  <= '0;
                        r_xings <= '0;
                        r_state <= S_CALC;
                    end else begin
                        r_count <= n_count;
                        r_sum   <= n_sum;
                        r_sumsq <= n_sumsq;
                        r_prev  <= r_samp;
                        r_xings <= n_xings;
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (w_load) begin
                        r_out   <= w_fin_result;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_sample_count   = r_out.sample_count;
    assign o_mean_q8        = r_out.mean_q8;
    assign o_variance_q8    = r_out.variance_q8;
    assign o_std_dev_q8     = r_out.std_dev_q8;
    assign o_zero_crossings = r_out.zero_crossings;
    assign o_overflow       = r_out.overflow;
    assign o_empty_set      = r_out.empty_set;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after taking a sample");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("sample count beyond capacity");

    a_clear_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_count == '0) && (r_sum == '0) && (r_xings == '0))
        else $error("set state not cleared after close");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_set) |-> (o_sample_count == '0) && (o_mean_q8 == '0)
            && (o_variance_q8 == '0) && (o_std_dev_q8 == '0) && !o_overflow)
        else $error("empty set result carries nonzero statistics");

endmodule

@@ tb/sv/running_mean_variance_stdev_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for running_mean_variance_stdev_unit: set statistics
// predicted per accepted sample and compared against every result taken.
// Depends on rmv_pkg (rtl/rmv_pkg.sv) and the unit itself.
module running_mean_variance_stdev_unit_tb;
    import rmv_pkg::*;

    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 200;
    localparam int  LONG_HOLD     = 700;
    localparam int  RANDOM_ITEMS  = 400;
    localparam time RUN_LIMIT_NS  = 5_000_000;

    // Holds the predicted statistics of every set closed but not yet seen.
    class stats_scoreboard;
        logic signed [SAMPLE_W-1:0] marker_reg;
        logic [COUNT_W-1:0]         limit_reg;
        int                         n;
        longint                     sum;
        longint                     sumsq;
        logic signed [SAMPLE_W-1:0] prev;
        logic [XING_W-1:0]          xings;
        t_result                    expected_stats[$];
        int                         failures;

        function new();
            marker_reg = END_MARKER_RST;
            limit_reg  = SET_LIMIT_RST;
            failures   = 0;
            clear_set();
        endfunction

        function void clear_set();
            n     = 0;
            sum   = 0;
            sumsq = 0;
            prev  = '0;
            xings = '0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            if (idx == CFG_END_MARKER)
                marker_reg = data;
            else
                limit_reg = data[COUNT_W-1:0];
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= x)
                    r = c;
            end
            return r;
        endfunction

        function void close_set(bit ovf);
            t_result         r;
            longint unsigned nn, am, q, mq, d, n2, v, sd;
            r  = '0;
            nn = 64'(n);
            r.sample_count = nn[COUNT_W-1:0];
            if (n != 0) begin
                am = (sum < 0) ? -sum : sum;
                q  = (am << 8) / nn;
                mq = (sum < 0) ? -q : q;
                d  = nn * sumsq - am * am;
                n2 = nn * nn;
                v  = (d << 8) / n2;
                sd = floor_sqrt((d << 16) / n2);
                r.mean_q8     = mq[MEAN_W-1:0];
                r.variance_q8 = v[VAR_W-1:0];
                r.std_dev_q8  = sd[SD_W-1:0];
            end
            r.zero_crossings = xings;
            r.overflow       = ovf;
            r.empty_set      = (n == 0);
            expected_stats.push_back(r);
            clear_set();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int lim;
            lim = int'(limit_reg);
            if (lim == 0)
                lim = 1;
            if (lim > CAPACITY)
                lim = CAPACITY;
            if (s == marker_reg) begin
                close_set(1'b0);
                return;
            end
            // strict sign change only; a zero on either side never counts
            if (n != 0 && ((s < 0 && prev > 0) || (s > 0 && prev < 0)))
                xings = xings + 1'b1;
            n     = n + 1;
            sum   = sum + s;
            sumsq = sumsq + longint'(s) * longint'(s);
            prev  = s;
            if (n >= lim)
                close_set(1'b1);
        endfunction

        function void report(string what, t_result want, t_result got);
            failures++;
            if (failures <= 10) begin
                $display("%s: exp n=%0d mean=%0d var=%0d sd=%0d x=%0d ovf=%b empty=%b",
                         what, want.sample_count, $signed(want.mean_q8), want.variance_q8,
                         want.std_dev_q8, want.zero_crossings, want.overflow,
                         want.empty_set);
                $display("%s: got n=%0d mean=%0d var=%0d sd=%0d x=%0d ovf=%b empty=%b",
                         what, got.sample_count, $signed(got.mean_q8), got.variance_q8,
                         got.std_dev_q8, got.zero_crossings, got.overflow,
                         got.empty_set);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_stats.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_stats.pop_front();
            if (got.sample_count !== want.sample_count || got.mean_q8 !== want.mean_q8 ||
                got.variance_q8 !== want.variance_q8 || got.std_dev_q8 !== want.std_dev_q8 ||
                got.zero_crossings !== want.zero_crossings ||
                got.overflow !== want.overflow || got.empty_set !== want.empty_set)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        function void flush_leftovers();
            while (expected_stats.size() != 0)
                report("missing result", expected_stats.pop_front(), '0);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    t_cfg_idx                   cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [COUNT_W-1:0]         sample_count;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic [VAR_W-1:0]           variance_q8;
    logic [SD_W-1:0]            std_dev_q8;
    logic [XING_W-1:0]          zero_crossings;
    logic                       overflow;
    logic                       empty_set;

    stats_scoreboard sb = new();
    int burst_left = 0;
    int random_items = 0;
    bit hold_req = 1'b0;

    running_mean_variance_stdev_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_sample         (sample),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_sample_count   (sample_count),
        .o_mean_q8        (mean_q8),
        .o_variance_q8    (variance_q8),
        .o_std_dev_q8     (std_dev_q8),
        .o_zero_crossings (zero_crossings),
        .o_overflow       (overflow),
        .o_empty_set      (empty_set)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Offers one sample and returns at the edge where the transaction completes.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(s);
        burst_left--;
    endtask

    // Waits for the unit to go idle, then writes both registers.
    task automatic set_registers(input logic signed [SAMPLE_W-1:0] marker,
                                 input logic [CFG_W-1:0] limit_word);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_END_MARKER;
        cfg_data  <= marker;
        @(posedge clk);
        sb.set_register(CFG_END_MARKER, marker);
        cfg_index <= CFG_SET_LIMIT;
        cfg_data  <= limit_word;
        @(posedge clk);
        sb.set_register(CFG_SET_LIMIT, limit_word);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
            int style, logic signed [SAMPLE_W-1:0] marker, int marker_pct);
        logic signed [SAMPLE_W-1:0] s;
        if ($urandom_range(0, 99) < marker_pct)
            return marker;
        case (style)
            0: s = SAMPLE_W'($urandom);
            1: begin
                case ($urandom_range(0, 6))
                    0: s = 16'sh8000;
                    1: s = 16'sh8001;
                    2: s = -16'sd1;
                    3: s = 16'sd0;
                    4: s = 16'sd1;
                    5: s = 16'sh7FFE;
                    default: s = 16'sh7FFF;
                endcase
            end
            default: s = SAMPLE_W'($signed($urandom_range(0, 20)) - 10);
        endcase
        return s;
    endfunction

    task automatic random_phase(input bit with_hold);
        int                         n_items;
        int                         style;
        int                         pct;
        logic signed [SAMPLE_W-1:0] mk;
        logic [CFG_W-1:0]           lim_word;
        case ($urandom_range(0, 4))
            0: mk = END_MARKER_RST;
            1: mk = 16'sh8000;
            2: mk = 16'sh7FFF;
            3: mk = 16'sd0;
            default: mk = SAMPLE_W'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0: lim_word = 16'd0;
            1: lim_word = 16'd1;
            2: lim_word = CFG_W'(CAPACITY);
            3: lim_word = {8'($urandom), 8'hFF};
            4: lim_word = CFG_W'($urandom_range(2, 10));
            5: lim_word = CFG_W'($urandom_range(1, CAPACITY));
            default: lim_word = CFG_W'($urandom);
        endcase
        set_registers(mk, lim_word);
        style   = $urandom_range(0, 2);
        n_items = $urandom_range(15, 45);
        case ($urandom_range(0, 2))
            0: pct = 5;
            1: pct = 15;
            default: pct = 30;
        endcase
        if (with_hold) begin
            // short sets while the result side is held off: fills the unit
            pct      = 35;
            n_items  = 40;
            hold_req = 1'b1;
        end
        repeat (n_items) begin
            send_sample(pick_sample(style, mk, pct));
            random_items++;
        end
    endtask

    // Result side: long hold once on request, otherwise shifting stall patterns.
    initial begin : receiver
        int hold_left;
        int pat_left;
        int pat_mode;
        bit hold_used;
        hold_left = 0;
        pat_left  = 0;
        pat_mode  = 0;
        hold_used = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 2);
                    pat_left = $urandom_range(20, 120);
                end else begin
                    pat_left--;
                end
                case (pat_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_result got;
        if (rst_n === 1'b1 && out_valid && !out_stall) begin
            got.sample_count   = sample_count;
            got.mean_q8        = mean_q8;
            got.variance_q8    = variance_q8;
            got.std_dev_q8     = std_dev_q8;
            got.zero_crossings = zero_crossings;
            got.overflow       = overflow;
            got.empty_set      = empty_set;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int p;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_END_MARKER;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two empty sets, then sets around zero and the extremes
        send_sample(16'sd9999);
        send_sample(16'sd9999);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(16'sh8000);
        send_sample(16'sd9999);
        send_sample(16'sd5);
        send_sample(16'sd9999);
        send_sample(-16'sd3);
        send_sample(-16'sd3);
        send_sample(-16'sd3);
        send_sample(16'sd9999);
        // negative mean that truncates toward zero
        send_sample(16'sd1);
        send_sample(-16'sd2);
        send_sample(16'sd0);
        send_sample(16'sd9999);
        // limit of one, then zero in the low byte (acts as one)
        set_registers(16'sd9999, 16'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        set_registers(16'sh8000, 16'hA500);
        send_sample(16'sd0);
        send_sample(16'sh8000);

        // full-size set: limit above capacity, alternating extremes
        set_registers(16'sd9999, 16'h5AFF);
        send_sample(16'sd9999);
        for (int i = 0; i < CAPACITY; i++) begin
            send_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
            random_items++;
        end

        p = 0;
        while (random_items < RANDOM_ITEMS) begin
            random_phase(p == 3);
            p++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftovers();
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
